// ===== sv/kvt_pkg.sv =====
// Shared types, codes and constants for the key/value table.
package kvt_pkg;

  localparam int unsigned CAPACITY_DEFAULT = 16;
  localparam int unsigned KEY_W   = 32;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned COUNT_W = 5;
  localparam int unsigned ENTRY_W = 1 + KEY_W + VAL_W;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_ADD    = 2'd1,
    OP_REMOVE = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_RESOLVE
  } state_t;

  typedef struct packed {
    logic load;
    logic addr_rst;
    logic addr_inc;
    logic clear_wr;
    logic read_en;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic addr_last;
    logic out_free;
  } status_t;

endpackage

// ===== sv/kvt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module kvt_ram #(
  parameter int unsigned WIDTH = kvt_pkg::ENTRY_W,
  parameter int unsigned DEPTH = kvt_pkg::CAPACITY_DEFAULT,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AddrW-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/kvt_ctrl.sv =====
// Controller state machine that sequences clearing, scanning and committing.
module kvt_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  kvt_pkg::status_t  status,
  output kvt_pkg::cmd_t     cmd
);

  kvt_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kvt_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      kvt_pkg::ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (status.addr_last) begin
          cmd.addr_rst = 1'b1;
          state_next   = kvt_pkg::ST_IDLE;
        end else begin
          cmd.addr_inc = 1'b1;
        end
      end
      kvt_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load     = 1'b1;
          cmd.addr_rst = 1'b1;
          state_next   = kvt_pkg::ST_SCAN;
        end
      end
      kvt_pkg::ST_SCAN: begin
        cmd.read_en = 1'b1;
        if (status.addr_last) begin
          cmd.addr_rst = 1'b1;
          state_next   = kvt_pkg::ST_DRAIN;
        end else begin
          cmd.addr_inc = 1'b1;
        end
      end
      kvt_pkg::ST_DRAIN: begin
        state_next = kvt_pkg::ST_RESOLVE;
      end
      kvt_pkg::ST_RESOLVE: begin
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_next = kvt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = kvt_pkg::ST_CLEAR;
      end
    endcase
  end

endmodule

// ===== sv/kvt_datapath.sv =====
// Datapath: request latch, entry memory, scan compare, commit and result register.
module kvt_datapath #(
  parameter int unsigned CAPACITY = kvt_pkg::CAPACITY_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  kvt_pkg::cmd_t                cmd,
  output kvt_pkg::status_t             status,
  input  logic [1:0]                   opcode,
  input  logic signed [kvt_pkg::KEY_W-1:0] key,
  input  logic [kvt_pkg::VAL_W-1:0]    value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         result_flag,
  output logic [kvt_pkg::VAL_W-1:0]    value_out,
  output logic [kvt_pkg::COUNT_W-1:0]  entry_count,
  output logic                         table_full
);

  localparam int unsigned IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned EW   = kvt_pkg::ENTRY_W;
  localparam int unsigned KW   = kvt_pkg::KEY_W;
  localparam int unsigned VW   = kvt_pkg::VAL_W;

  logic [IdxW-1:0] addr;
  logic            cmp_en;
  logic [IdxW-1:0] cmp_idx;
  logic            hit;
  logic [IdxW-1:0] hit_idx;
  logic [VW-1:0]   hit_value;
  logic            free_found;
  logic [IdxW-1:0] free_idx;
  kvt_pkg::op_t    req_op;
  logic [KW-1:0]   req_key;
  logic [VW-1:0]   req_value;
  logic [CntW-1:0] count;

  logic [EW-1:0]   rdata;
  logic            rd_valid;
  logic [KW-1:0]   rd_key;
  logic [VW-1:0]   rd_val;

  logic            c_we;
  logic [IdxW-1:0] c_addr;
  logic [EW-1:0]   c_data;
  logic            c_flag;
  logic [VW-1:0]   c_vout;
  logic            c_full;
  logic [CntW-1:0] count_next;

  logic            we;
  logic [IdxW-1:0] waddr;
  logic [EW-1:0]   wdata;

  assign rd_valid = rdata[EW-1];
  assign rd_key   = rdata[VW +: KW];
  assign rd_val   = rdata[VW-1:0];

  assign status.addr_last = (addr == IdxW'(CAPACITY - 1));
  assign status.out_free  = !out_valid || out_ready;

  kvt_ram #(
    .WIDTH (EW),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (cmd.read_en),
    .raddr (addr),
    .rdata (rdata)
  );

  always_comb begin
    c_we       = 1'b0;
    c_addr     = hit_idx;
    c_data     = '0;
    c_flag     = 1'b0;
    c_vout     = '0;
    c_full     = 1'b0;
    count_next = count;
    unique case (req_op)
      kvt_pkg::OP_LOOKUP: begin
        c_flag = hit;
        if (hit) begin
          c_vout = hit_value;
        end
      end
      kvt_pkg::OP_ADD: begin
        if (hit) begin
          c_we   = 1'b1;
          c_data = {1'b1, req_key, req_value};
        end else if (free_found) begin
          c_we       = 1'b1;
          c_addr     = free_idx;
          c_data     = {1'b1, req_key, req_value};
          count_next = count + CntW'(1);
          c_flag     = 1'b1;
        end else begin
          c_full = 1'b1;
        end
      end
      kvt_pkg::OP_REMOVE: begin
        if (hit) begin
          c_we   = 1'b1;
          c_data = {1'b0, req_key, hit_value};
          c_flag = 1'b1;
          if (count != '0) begin
            count_next = count - CntW'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = addr;
    wdata = '0;
    if (cmd.clear_wr) begin
      we = 1'b1;
    end else if (cmd.commit) begin
      we    = c_we;
      waddr = c_addr;
      wdata = c_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      addr      <= '0;
      cmp_en    <= 1'b0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.addr_rst) begin
        addr <= '0;
      end else if (cmd.addr_inc) begin
        addr <= addr + IdxW'(1);
      end
      cmp_en <= cmd.read_en;
      if (cmd.commit) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read_en) begin
      cmp_idx <= addr;
    end
    if (cmd.load) begin
      req_op     <= kvt_pkg::op_t'(opcode);
      req_key    <= $unsigned(key);
      req_value  <= value;
      hit        <= 1'b0;
      free_found <= 1'b0;
    end else if (cmp_en) begin
      if (rd_valid && (rd_key == req_key) && !hit) begin
        hit       <= 1'b1;
        hit_idx   <= cmp_idx;
        hit_value <= rd_val;
      end
      if (!rd_valid && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= cmp_idx;
      end
    end
    if (cmd.commit) begin
      result_flag <= c_flag;
      value_out   <= c_vout;
      entry_count <= kvt_pkg::COUNT_W'(count_next);
      table_full  <= c_full;
    end
  end

endmodule

// ===== sv/key_value_table_unit.sv =====
// Top level of the key/value table: controller plus datapath.
// A transaction is accepted in idle, then scanned, drained and resolved; its result is registered
// at commit. The entry memory's single read port compares one stored entry a cycle during the scan.
// A new transaction is taken only once the last one is committed, also while the last
// result waits; a result that still waits holds the next one back in its resolve state.
// Reset clears every memory entry with in_ready low; out_valid and count are zero.
module key_value_table_unit #(
  parameter int unsigned CAPACITY = kvt_pkg::CAPACITY_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      opcode,
  input  logic signed [kvt_pkg::KEY_W-1:0] key,
  input  logic [kvt_pkg::VAL_W-1:0]       value,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            result_flag,
  output logic [kvt_pkg::VAL_W-1:0]       value_out,
  output logic [kvt_pkg::COUNT_W-1:0]     entry_count,
  output logic                            table_full
);

  kvt_pkg::cmd_t    cmd;
  kvt_pkg::status_t status;

  kvt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  kvt_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .opcode      (opcode),
    .key         (key),
    .value       (value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .result_flag (result_flag),
    .value_out   (value_out),
    .entry_count (entry_count),
    .table_full  (table_full)
  );

endmodule

// ===== sv/kvt_checker.sv =====
// Port-level checker for the key/value table, bound to the top level.
module kvt_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic                            result_flag,
  input logic [kvt_pkg::VAL_W-1:0]       value_out,
  input logic [kvt_pkg::COUNT_W-1:0]     entry_count,
  input logic                            table_full
);

  // The table is cleared after reset, so nothing is accepted or reported.
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !in_ready && !out_valid)
    else $error("transaction possible right after reset");

  // Only one transaction is in work, so an accepted input closes the input side.
  a_in_single: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a transaction is in work");

  // A rejected add neither creates an entry nor returns a value.
  a_full_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && table_full |-> !result_flag && value_out == '0)
    else $error("full result carries flag or value");

  // A nonzero value is only returned by a successful lookup.
  a_value_needs_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid && value_out != '0 |-> result_flag)
    else $error("value returned without flag");

  // A stalled result holds its fields.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_flag)
      && $stable(value_out) && $stable(entry_count) && $stable(table_full))
    else $error("stalled result changed");

endmodule

bind key_value_table_unit kvt_checker u_kvt_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .result_flag (result_flag),
  .value_out   (value_out),
  .entry_count (entry_count),
  .table_full  (table_full)
);
